// ===== rtl/core/pfrc_pkg.sv =====
// shared types and constants of the per-flow rate counter
// no dependencies
`default_nettype none
package pfrc_pkg;
    localparam int unsigned KEY_W  = 56;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned TIME_W = 64;
    localparam int unsigned PKT_W  = 32;
    localparam int unsigned BYTE_W = 40;
    localparam int unsigned WIN_W  = 32;
    localparam logic [WIN_W-1:0] WIN_RESET = 32'd1000000000;
    localparam logic [1:0] ADDR_WINDOW = 2'd0;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] now;
    } t_item;

    typedef struct packed {
        logic [PKT_W-1:0]  pkts;
        logic [BYTE_W-1:0] bytes;
    } t_result;

    typedef struct packed {
        logic [PKT_W-1:0]  pkts;
        logic [BYTE_W-1:0] bytes;
        logic [TIME_W-1:0] wend;
    } t_entry;
endpackage
`default_nettype wire

// ===== rtl/core/pfrc_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module pfrc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]              o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/pfrc_fifo.sv =====
// small register-based queue
// no dependencies; depth must be a power of two
`default_nettype none
module pfrc_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/pfrc_back.sv =====
// flow table engine: key scan, read-modify-write of counters, insert on miss while the table has room
// depends on pfrc_pkg and pfrc_ram
`default_nettype none
module pfrc_back #(
    parameter int unsigned TABLE_ENTRIES = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [pfrc_pkg::WIN_W-1:0]    i_window_len,
    input  wire logic                          i_req_empty,
    input  wire pfrc_pkg::t_item               i_req,
    output logic                               o_req_pop,
    input  wire logic                          i_res_full,
    output logic                               o_res_push,
    output pfrc_pkg::t_result                  o_res
);
    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned KW    = pfrc_pkg::KEY_W;
    localparam int unsigned EW    = $bits(pfrc_pkg::t_entry);
    localparam int unsigned TW    = pfrc_pkg::TIME_W;
    localparam int unsigned PW    = pfrc_pkg::PKT_W;
    localparam int unsigned BW    = pfrc_pkg::BYTE_W;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_READ, S_UPD, S_MISS} t_state;

    t_state          r_state;
    pfrc_pkg::t_item r_item;
    logic [CNT_W-1:0] r_fill, r_issue;
    logic [IDX_W-1:0] r_cmp_idx, r_hit;
    logic             r_cmp_pend;

    logic             key_rd_en, key_wr_en, dat_rd_en, dat_wr_en;
    logic [IDX_W-1:0] key_rd_addr, dat_rd_addr, wr_addr;
    logic [KW-1:0]    key_rdata;
    logic [EW-1:0]    dat_rdata_raw;
    pfrc_pkg::t_entry dat_rdata, dat_wdata, fresh, bumped;
    logic [TW:0]      wend_sum;
    logic [TW-1:0]    wend_new;
    logic [BW:0]      byte_sum;
    logic             issuing, key_match, expired, table_full;

    assign issuing    = (r_state == S_SCAN) && (r_issue < r_fill);
    assign key_match  = r_cmp_pend && (key_rdata == r_item.key);
    assign table_full = (r_fill == CNT_W'(TABLE_ENTRIES));
    assign dat_rdata  = pfrc_pkg::t_entry'(dat_rdata_raw);

    // saturating window end and counter updates
    always_comb begin
        wend_sum = {1'b0, r_item.now} + {{(TW + 1 - pfrc_pkg::WIN_W){1'b0}}, i_window_len};
        wend_new = wend_sum[TW] ? {TW{1'b1}} : wend_sum[TW-1:0];
        byte_sum = {1'b0, dat_rdata.bytes}
                 + {{(BW + 1 - pfrc_pkg::LEN_W){1'b0}}, r_item.len};
        expired  = r_item.now > dat_rdata.wend;

        fresh.pkts  = PW'(1);
        fresh.bytes = {{(BW - pfrc_pkg::LEN_W){1'b0}}, r_item.len};
        fresh.wend  = wend_new;

        bumped.pkts  = (dat_rdata.pkts == {PW{1'b1}}) ? {PW{1'b1}}
                                                       : dat_rdata.pkts + PW'(1);
        bumped.bytes = byte_sum[BW] ? {BW{1'b1}} : byte_sum[BW-1:0];
        bumped.wend  = dat_rdata.wend;
    end

    always_comb begin
        o_req_pop   = (r_state == S_IDLE) && !i_req_empty && !i_res_full;
        key_rd_en   = issuing;
        key_rd_addr = r_issue[IDX_W-1:0];
        dat_rd_en   = (r_state == S_READ);
        dat_rd_addr = r_hit;
        key_wr_en   = (r_state == S_MISS) && !table_full;
        dat_wr_en   = key_wr_en;
        wr_addr     = r_fill[IDX_W-1:0];
        dat_wdata   = fresh;
        o_res_push  = 1'b0;
        o_res.pkts  = fresh.pkts;
        o_res.bytes = fresh.bytes;
        unique case (r_state)
            S_UPD: begin
                dat_wr_en  = 1'b1;
                wr_addr    = r_hit;
                dat_wdata  = expired ? fresh : bumped;
                o_res_push = 1'b1;
                o_res.pkts  = dat_wdata.pkts;
                o_res.bytes = dat_wdata.bytes;
            end
            S_MISS: begin
                o_res_push = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_issue    <= '0;
            r_cmp_pend <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_req_pop) begin
                        r_item     <= i_req;
                        r_issue    <= '0;
                        r_cmp_pend <= 1'b0;
                        r_state    <= (r_fill == '0) ? S_MISS : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (issuing) begin
                        r_issue <= r_issue + CNT_W'(1);
                    end
                    r_cmp_pend <= issuing;
                    r_cmp_idx  <= r_issue[IDX_W-1:0];
                    if (key_match) begin
                        r_hit   <= r_cmp_idx;
                        r_state <= S_READ;
                    end else if (r_cmp_pend && !issuing) begin
                        r_state <= S_MISS;
                    end
                end
                S_READ: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_state <= S_IDLE;
                end
                S_MISS: begin
                    if (!table_full) begin
                        r_fill <= r_fill + CNT_W'(1);
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    pfrc_ram #(.WIDTH(KW), .DEPTH(TABLE_ENTRIES)) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (key_wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_item.key),
        .i_rd_en   (key_rd_en),
        .i_rd_addr (key_rd_addr),
        .o_rd_data (key_rdata)
    );

    pfrc_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_dat_ram (
        .i_clk     (i_clk),
        .i_wr_en   (dat_wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (dat_wdata),
        .i_rd_en   (dat_rd_en),
        .i_rd_addr (dat_rd_addr),
        .o_rd_data (dat_rdata_raw)
    );
endmodule
`default_nettype wire

// ===== rtl/core/per_flow_rate_counter_unit.sv =====
// top level of the per-flow fixed-window packet and byte counter
// depends on pfrc_pkg, pfrc_fifo, pfrc_back (and pfrc_ram below it)
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  request   | push / full        | i_src_ip, i_src_port, i_protocol,
//            |                    | i_packet_length, i_now_ns
//  result    | empty / pop        | o_packets_in_window, o_bytes_in_window
//  config    | apb psel..pready   | window_length_ns at byte address 0
//
// a miss into an empty table skips the scan; otherwise the key memory is
// scanned one entry per cycle through its single read port, stopping at the
// first match; a hit adds a counter read and a write-back. flows are stored
// in arrival order, so the lowest free slot is always the fill count and no
// clearing pass is needed after reset. two-entry queues on both sides let the
// source and the sink stall freely.
`default_nettype none
module per_flow_rate_counter_unit #(
    parameter int unsigned TABLE_ENTRIES = 256
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // request side
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [31:0]                      i_src_ip,
    input  wire logic [15:0]                      i_src_port,
    input  wire logic [7:0]                       i_protocol,
    input  wire logic [15:0]                      i_packet_length,
    input  wire logic [63:0]                      i_now_ns,
    // result side
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [31:0]                           o_packets_in_window,
    output logic [39:0]                           o_bytes_in_window,
    // configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [1:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    localparam int unsigned ITEM_W = $bits(pfrc_pkg::t_item);
    localparam int unsigned RES_W  = $bits(pfrc_pkg::t_result);

    logic [pfrc_pkg::WIN_W-1:0] r_window_len;
    pfrc_pkg::t_item   req_in, req_out;
    pfrc_pkg::t_result res_in, res_out;
    logic [ITEM_W-1:0] req_out_raw;
    logic [RES_W-1:0]  res_out_raw;
    logic              req_empty, req_pop, res_full, res_push;

    // config register, written on the apb access phase
    assign pready = 1'b1;
    assign prdata = (paddr == pfrc_pkg::ADDR_WINDOW) ? r_window_len : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= pfrc_pkg::WIN_RESET;
        end else if (psel && penable && pwrite && paddr == pfrc_pkg::ADDR_WINDOW) begin
            r_window_len <= pwdata;
        end
    end

    // flow key is {ip, port, protocol}
    assign req_in.key = {i_src_ip, i_src_port, i_protocol};
    assign req_in.len = i_packet_length;
    assign req_in.now = i_now_ns;
    assign req_out    = pfrc_pkg::t_item'(req_out_raw);

    pfrc_fifo #(.WIDTH(ITEM_W), .DEPTH(2)) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (req_in),
        .o_full  (full),
        .i_pop   (req_pop),
        .o_data  (req_out_raw),
        .o_empty (req_empty)
    );

    pfrc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_window_len (r_window_len),
        .i_req_empty  (req_empty),
        .i_req        (req_out),
        .o_req_pop    (req_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    // results wait here until the sink pops them
    pfrc_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out_raw),
        .o_empty (empty)
    );

    assign res_out             = pfrc_pkg::t_result'(res_out_raw);
    assign o_packets_in_window = res_out.pkts;
    assign o_bytes_in_window   = res_out.bytes;
endmodule
`default_nettype wire
